### hdl/dtls_pkg.sv
// ----------------------------------------------------------------------------
// dtls_pkg
// Types, constants and helpers for the density traffic light sequencer.
// ----------------------------------------------------------------------------
package dtls_pkg;

    localparam int APPROACH_COUNT_DEF = 4;
    localparam int MAX_APPROACHES     = 8;

    localparam int TICK_W     = 8;
    localparam int LAMP_W     = 4;
    localparam int SERVED_W   = 2;
    localparam int DIGIT_W    = 4;
    localparam int HUNDREDS_W = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TICK_W-1:0] BASE_GREEN_RST   = 8'd15;
    localparam logic [TICK_W-1:0] MEDIUM_GREEN_RST = 8'd30;
    localparam logic [TICK_W-1:0] LONG_GREEN_RST   = 8'd60;
    localparam logic [TICK_W-1:0] SAMPLE_WIN_RST   = 8'd3;
    localparam logic [TICK_W-1:0] TICK_MAX         = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_GREEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIN   = 3'd3;

    typedef enum logic [1:0] {
        LEN_BASE   = 2'd0,
        LEN_MEDIUM = 2'd1,
        LEN_LONG   = 2'd2
    } length_sel_t;

    typedef struct packed {
        logic [HUNDREDS_W-1:0] hundreds;
        logic [DIGIT_W-1:0]    tens;
        logic [DIGIT_W-1:0]    ones;
    } digits_t;

    // tens via multiply by 205 and shift by 11, exact below 1029
    function automatic digits_t to_decimal(input logic [TICK_W-1:0] value);
        logic [6:0]  rem;
        logic [14:0] prod;
        digits_t     d;
        if (value >= 8'd200) begin
            d.hundreds = 2'd2;
            rem        = 7'(value - 8'd200);
        end else if (value >= 8'd100) begin
            d.hundreds = 2'd1;
            rem        = 7'(value - 8'd100);
        end else begin
            d.hundreds = 2'd0;
            rem        = 7'(value);
        end
        prod   = 15'(rem) * 15'd205;
        d.tens = prod[14:11];
        d.ones = 4'(rem - 7'(7'(d.tens) * 7'd10));
        return d;
    endfunction

endpackage

### hdl/density_traffic_light_sequencer.sv
// ----------------------------------------------------------------------------
// density_traffic_light_sequencer
// Round-robin green phases with sensor-selected, sticky green lengths.
// ----------------------------------------------------------------------------
// One input item is one time tick and yields exactly one result item. A tick
// passes through an input register, then a single evaluation stage that
// updates the served approach, its elapsed count and its length choice and
// loads the result register, from which the result is presented; a new tick
// is accepted every cycle while results are taken; when the output side holds
// off, the input register takes one more tick and then stalls. Configuration
// writes complete in the cycle they are offered.
module density_traffic_light_sequencer #(
    parameter int APPROACH_COUNT = dtls_pkg::APPROACH_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtls_pkg::TICK_W-1:0]         cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dtls_pkg::LAMP_W-1:0]         sensor_low,
    input  logic [dtls_pkg::LAMP_W-1:0]         sensor_high,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dtls_pkg::LAMP_W-1:0]         green_lamps,
    output logic [dtls_pkg::LAMP_W-1:0]         red_lamps,
    output logic [dtls_pkg::SERVED_W-1:0]       served_approach,
    output logic [dtls_pkg::TICK_W-1:0]         elapsed_ticks,
    output logic [dtls_pkg::TICK_W-1:0]         green_length,
    output logic [dtls_pkg::DIGIT_W-1:0]        ones_digit,
    output logic [dtls_pkg::DIGIT_W-1:0]        tens_digit,
    output logic [dtls_pkg::HUNDREDS_W-1:0]     hundreds_digit,
    output logic                                phase_end
);

    localparam int IDX_W = $clog2(APPROACH_COUNT);
    localparam logic [dtls_pkg::LAMP_W-1:0] ALL_MASK =
        dtls_pkg::LAMP_W'((9'd1 << APPROACH_COUNT) - 9'd1);

    // configuration
    logic [dtls_pkg::TICK_W-1:0] base_green_reg;
    logic [dtls_pkg::TICK_W-1:0] medium_green_reg;
    logic [dtls_pkg::TICK_W-1:0] long_green_reg;
    logic [dtls_pkg::TICK_W-1:0] sample_win_reg;

    // sequencer state
    logic [IDX_W-1:0]              approach_reg;
    logic [IDX_W-1:0]              approach_next;
    logic [dtls_pkg::TICK_W-1:0]   counter_reg;
    logic [dtls_pkg::TICK_W-1:0]   counter_next;
    dtls_pkg::length_sel_t         choice_reg [APPROACH_COUNT];
    dtls_pkg::length_sel_t         choice_next;

    // input stage
    logic                          s1_valid_reg;
    logic [dtls_pkg::LAMP_W-1:0]   s1_low_reg;
    logic [dtls_pkg::LAMP_W-1:0]   s1_high_reg;

    // result stage
    logic                          out_valid_reg;
    logic [dtls_pkg::LAMP_W-1:0]   green_reg;
    logic [dtls_pkg::LAMP_W-1:0]   red_reg;
    logic [dtls_pkg::SERVED_W-1:0] served_reg;
    logic [dtls_pkg::TICK_W-1:0]   elapsed_reg;
    logic [dtls_pkg::TICK_W-1:0]   length_reg;
    dtls_pkg::digits_t             digits_reg;
    logic                          end_reg;

    // evaluation
    logic                          out_load_ok;
    logic                          s2_fire;
    logic                          in_fire;
    logic [dtls_pkg::MAX_APPROACHES-1:0] served_mask;
    logic                          lo_hit;
    logic                          hi_hit;
    logic [dtls_pkg::TICK_W-1:0]   elapsed_c;
    logic [dtls_pkg::TICK_W-1:0]   length_c;
    logic                          end_c;
    logic [IDX_W:0]                approach_inc;
    logic [dtls_pkg::LAMP_W-1:0]   green_c;
    logic [dtls_pkg::LAMP_W-1:0]   red_c;

    assign cfg_ready   = 1'b1;
    assign out_load_ok = !out_valid_reg || out_ready;
    assign s2_fire     = s1_valid_reg && out_load_ok;
    assign in_ready    = !s1_valid_reg || out_load_ok;
    assign in_fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_green_reg   <= dtls_pkg::BASE_GREEN_RST;
            medium_green_reg <= dtls_pkg::MEDIUM_GREEN_RST;
            long_green_reg   <= dtls_pkg::LONG_GREEN_RST;
            sample_win_reg   <= dtls_pkg::SAMPLE_WIN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dtls_pkg::REG_BASE_GREEN:   base_green_reg   <= cfg_data;
                dtls_pkg::REG_MEDIUM_GREEN: medium_green_reg <= cfg_data;
                dtls_pkg::REG_LONG_GREEN:   long_green_reg   <= cfg_data;
                dtls_pkg::REG_SAMPLE_WIN:   sample_win_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        served_mask = dtls_pkg::MAX_APPROACHES'(1) << approach_reg;
        lo_hit      = |(s1_low_reg & served_mask[dtls_pkg::LAMP_W-1:0]);
        hi_hit      = |(s1_high_reg & served_mask[dtls_pkg::LAMP_W-1:0]);

        choice_next = choice_reg[approach_reg];
        if (counter_reg <= sample_win_reg)
        begin
            if (hi_hit)
                choice_next = dtls_pkg::LEN_LONG;
            else if (lo_hit)
                choice_next = dtls_pkg::LEN_MEDIUM;
        end

        case (choice_next)
            dtls_pkg::LEN_LONG:   length_c = long_green_reg;
            dtls_pkg::LEN_MEDIUM: length_c = medium_green_reg;
            default:              length_c = base_green_reg;
        endcase

        elapsed_c = (counter_reg == dtls_pkg::TICK_MAX) ? dtls_pkg::TICK_MAX
                                                       : counter_reg + 8'd1;
        end_c     = elapsed_c >= length_c;

        approach_inc = {1'b0, approach_reg} + (IDX_W+1)'(1);
        if (end_c)
        begin
            green_c      = '0;
            red_c        = ALL_MASK;
            counter_next = '0;
            if (approach_inc >= (IDX_W+1)'(APPROACH_COUNT))
                approach_next = '0;
            else
                approach_next = approach_inc[IDX_W-1:0];
        end
        else
        begin
            green_c       = served_mask[dtls_pkg::LAMP_W-1:0];
            red_c         = ALL_MASK & ~served_mask[dtls_pkg::LAMP_W-1:0];
            counter_next  = elapsed_c;
            approach_next = approach_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            approach_reg  <= '0;
            counter_reg   <= '0;
            for (int i = 0; i < APPROACH_COUNT; i++)
                choice_reg[i] <= dtls_pkg::LEN_BASE;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_load_ok)
                out_valid_reg <= s1_valid_reg;
            if (s2_fire)
            begin
                approach_reg             <= approach_next;
                counter_reg              <= counter_next;
                choice_reg[approach_reg] <= choice_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_low_reg  <= sensor_low;
            s1_high_reg <= sensor_high;
        end
        if (s2_fire)
        begin
            green_reg   <= green_c;
            red_reg     <= red_c;
            served_reg  <= dtls_pkg::SERVED_W'(approach_reg);
            elapsed_reg <= elapsed_c;
            length_reg  <= length_c;
            digits_reg  <= dtls_pkg::to_decimal(elapsed_c);
            end_reg     <= end_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign green_lamps     = green_reg;
    assign red_lamps       = red_reg;
    assign served_approach = served_reg;
    assign elapsed_ticks   = elapsed_reg;
    assign green_length    = length_reg;
    assign ones_digit      = digits_reg.ones;
    assign tens_digit      = digits_reg.tens;
    assign hundreds_digit  = digits_reg.hundreds;
    assign phase_end       = end_reg;

`ifndef NO_ASSERTIONS
    a_counter_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != dtls_pkg::TICK_MAX)
        else $error("green counter reached its limit without a phase end");

    a_approach_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        approach_reg < IDX_W'(APPROACH_COUNT - 1) || approach_reg == IDX_W'(APPROACH_COUNT - 1))
        else $error("served approach out of range");

    a_end_advances: assert property (@(posedge clk) disable iff (!rst_n)
        s2_fire && end_c |=> approach_reg == $past(approach_next) && counter_reg == '0)
        else $error("phase end did not advance the approach");

    a_end_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |-> green_reg == '0 && red_reg == ALL_MASK)
        else $error("phase end result shows a green lamp");

    a_running_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !end_reg |-> elapsed_reg < length_reg)
        else $error("running phase at or past its green length");
`endif

endmodule
